@@ sv/dltq_pkg.sv @@
package dltq_pkg;

  localparam int DELTA_W = 27;
  localparam int MS_PER_SEC = 1000;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_FIRE = 1'b1
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         id;
    logic               load;
    logic [DELTA_W-1:0] period;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UL_STEP,
    ST_UL_STW,
    ST_UL_SRD,
    ST_UL_SWT,
    ST_UL_NRD,
    ST_UL_NWR,
    ST_UL_LINK,
    ST_PER,
    ST_PER_WT,
    ST_IN_BEG,
    ST_IN_STEP,
    ST_IN_WT,
    ST_IN_FIN,
    ST_IN_LINK,
    ST_ACK,
    ST_TK_RD,
    ST_TK_WT,
    ST_FR_RD,
    ST_FR_EMIT
  } st_t;

endpackage

@@ sv/dltq_if.sv @@
interface dltq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  timer_id;
  logic        load_period;
  logic [15:0] period_secs;
  logic [15:0] period_msecs;

  modport source(output valid, mode, timer_id, load_period, period_secs, period_msecs,
                 input ready);
  modport sink(input valid, mode, timer_id, load_period, period_secs, period_msecs,
               output ready);
endinterface

interface dltq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] fired_id;
  logic       last;

  modport source(output valid, kind, fired_id, last, input ready);
  modport sink(input valid, kind, fired_id, last, output ready);
endinterface

@@ sv/delta_list_timer_queue.sv @@
// Bank of NUM_TIMERS one-shot timers kept as a delta list sorted by expiry.
// The in_ch channel carries start, cancel and one-millisecond tick commands;
// every command yields one acknowledge on out_ch, except a tick that fires,
// which yields one result per expired timer with last set on the final one.
// A two-entry command queue sits between the input and the list engine, so
// commands are taken while the engine works or while a result waits.
// The engine walks the list one linked slot at a time through memories
// with registered reads. A start or cancel walks over the list entries
// ahead of its slot; a quiet tick reads only the head entry, and a firing
// tick emits one result per fired timer. One command is in the engine at
// a time.
// Reset empties the list and the queue and marks all stored periods invalid.
// When the receiver holds out_ch.ready low, the result stays in the output
// register, the engine waits, and the input stalls once the queue is full.
module delta_list_timer_queue import dltq_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dltq_in_if.sink    in_ch,
  dltq_out_if.source out_ch
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  dltq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  dltq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_ch(out_ch)
  );

endmodule

@@ sv/dltq_ram.sv @@
module dltq_ram import dltq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/dltq_front.sv @@
module dltq_front import dltq_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  dltq_in_if.sink  in_ch,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t               q_r [2];
  logic               wp_r, wp_nxt;
  logic               rp_r, rp_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push;
  cmd_t               cls;
  logic [31:0]        prod;
  logic [DELTA_W-1:0] per;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;

  assign prod = 32'(in_ch.period_secs) * 32'(MS_PER_SEC);
  assign per  = prod[DELTA_W-1:0] + DELTA_W'(in_ch.period_msecs);

  always_comb begin
    cls.id     = in_ch.timer_id;
    cls.load   = in_ch.load_period;
    cls.period = per;
    if (mode_t'(in_ch.mode) == MODE_TICK) begin
      cls.op = OP_TICK;
    end else if (mode_t'(in_ch.mode) == MODE_NONE || 32'(in_ch.timer_id) >= NUM_TIMERS) begin
      cls.op = OP_NOP;
    end else if (mode_t'(in_ch.mode) == MODE_START) begin
      cls.op = OP_START;
    end else begin
      cls.op = OP_CANCEL;
    end
  end

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ cmd_pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

endmodule

@@ sv/dltq_back.sv @@
module dltq_back import dltq_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  dltq_out_if.source  out_ch
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);
  localparam logic [LW-1:0] NULL_LNK = LW'(NUM_TIMERS);

  st_t                st_r, st_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [LW-1:0]      cur_r, cur_nxt;
  logic [LW-1:0]      prev_r, prev_nxt;
  logic [LW-1:0]      nx_r, nx_nxt;
  logic [LW-1:0]      hd_r, hd_nxt;
  logic [DELTA_W-1:0] dlt_r, dlt_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;
  logic [NUM_TIMERS-1:0] pend_r, pend_nxt;
  logic [NUM_TIMERS-1:0] pvld_r, pvld_nxt;
  logic               ov_r, ov_nxt;
  logic               okind_r, okind_nxt;
  logic [3:0]         oid_r, oid_nxt;
  logic               olast_r, olast_nxt;

  logic               d_we, n_we, p_we, rd_en, p_re;
  logic [IW-1:0]      d_wa, n_wa, rd_a, sid;
  logic [DELTA_W-1:0] d_wd, dq, pq;
  logic [LW-1:0]      n_wd, nq;
  logic [IW+3:0]      id_ext;
  logic [LW+3:0]      cur_ext;
  logic [LW-1:0]      sl;
  logic               out_free, more;
  logic [DELTA_W-1:0] dec;

  assign id_ext   = {{IW{1'b0}}, cmd_r.id};
  assign sid      = id_ext[IW-1:0];
  assign sl       = {1'b0, sid};
  assign cur_ext  = {4'd0, cur_r};
  assign out_free = !ov_r || out_ch.ready;
  assign more     = (nx_r != NULL_LNK) && (dq == '0);
  assign dec      = (dq == '0) ? '0 : dq - DELTA_W'(1);

  dltq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(DELTA_W)) u_delta (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd),
    .re(rd_en), .raddr(rd_a), .rdata(dq)
  );

  dltq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(LW)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd),
    .re(rd_en), .raddr(rd_a), .rdata(nq)
  );

  dltq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(DELTA_W)) u_period (
    .clk(clk), .we(p_we), .waddr(sid), .wdata(cmd_r.period),
    .re(p_re), .raddr(sid), .rdata(pq)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_NOP:  st_nxt = ST_ACK;
            OP_TICK: st_nxt = (hd_r == NULL_LNK) ? ST_ACK : ST_TK_RD;
            default: begin
              if (pend_r[cmd.id[IW-1:0]]) begin
                st_nxt = ST_UL_STEP;
              end else begin
                st_nxt = (cmd.op == OP_START) ? ST_PER : ST_ACK;
              end
            end
          endcase
        end
      end
      ST_UL_STEP: st_nxt = (cur_r == sl) ? ST_UL_SRD : ST_UL_STW;
      ST_UL_STW:  st_nxt = ST_UL_STEP;
      ST_UL_SRD:  st_nxt = ST_UL_SWT;
      ST_UL_SWT:  st_nxt = (nq != NULL_LNK) ? ST_UL_NRD : ST_UL_LINK;
      ST_UL_NRD:  st_nxt = ST_UL_NWR;
      ST_UL_NWR:  st_nxt = ST_UL_LINK;
      ST_UL_LINK: st_nxt = (cmd_r.op == OP_START) ? ST_PER : ST_ACK;
      ST_PER:     st_nxt = cmd_r.load ? ST_IN_BEG : ST_PER_WT;
      ST_PER_WT:  st_nxt = ST_IN_BEG;
      ST_IN_BEG:  st_nxt = (rem_r == '0) ? ST_ACK : ST_IN_STEP;
      ST_IN_STEP: st_nxt = (cur_r == NULL_LNK) ? ST_IN_FIN : ST_IN_WT;
      ST_IN_WT:   st_nxt = (dq <= rem_r) ? ST_IN_STEP : ST_IN_FIN;
      ST_IN_FIN:  st_nxt = ST_IN_LINK;
      ST_IN_LINK: st_nxt = ST_ACK;
      ST_ACK:     st_nxt = out_free ? ST_IDLE : ST_ACK;
      ST_TK_RD:   st_nxt = ST_TK_WT;
      ST_TK_WT:   st_nxt = (dec != '0) ? ST_ACK : ST_FR_RD;
      ST_FR_RD:   st_nxt = ST_FR_EMIT;
      ST_FR_EMIT: begin
        if (out_free) begin
          st_nxt = more ? ST_FR_RD : ST_IDLE;
        end
      end
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    cmd_nxt   = cmd_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    nx_nxt    = nx_r;
    hd_nxt    = hd_r;
    dlt_nxt   = dlt_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    pvld_nxt  = pvld_r;
    ov_nxt    = ov_r && !out_ch.ready;
    okind_nxt = okind_r;
    oid_nxt   = oid_r;
    olast_nxt = olast_r;
    d_we      = 1'b0;
    d_wa      = cur_r[IW-1:0];
    d_wd      = '0;
    n_we      = 1'b0;
    n_wa      = prev_r[IW-1:0];
    n_wd      = '0;
    p_we      = 1'b0;
    p_re      = 1'b0;
    rd_en     = 1'b0;
    rd_a      = cur_r[IW-1:0];
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd;
          cur_nxt  = hd_r;
          prev_nxt = NULL_LNK;
        end
      end
      ST_UL_STEP: begin
        if (cur_r != sl) begin
          rd_en    = 1'b1;
          prev_nxt = cur_r;
        end
      end
      ST_UL_STW: cur_nxt = nq;
      ST_UL_SRD: begin
        rd_en = 1'b1;
        rd_a  = sid;
      end
      ST_UL_SWT: begin
        nx_nxt  = nq;
        dlt_nxt = dq;
      end
      ST_UL_NRD: begin
        rd_en = 1'b1;
        rd_a  = nx_r[IW-1:0];
      end
      ST_UL_NWR: begin
        d_we = 1'b1;
        d_wa = nx_r[IW-1:0];
        d_wd = dq + dlt_r;
      end
      ST_UL_LINK: begin
        if (prev_r == NULL_LNK) begin
          hd_nxt = nx_r;
        end else begin
          n_we = 1'b1;
          n_wd = nx_r;
        end
        pend_nxt[sid] = 1'b0;
      end
      ST_PER: begin
        if (cmd_r.load) begin
          p_we          = 1'b1;
          pvld_nxt[sid] = 1'b1;
          rem_nxt       = cmd_r.period;
        end else begin
          p_re = 1'b1;
        end
      end
      ST_PER_WT: rem_nxt = pvld_r[sid] ? pq : '0;
      ST_IN_BEG: begin
        cur_nxt  = hd_r;
        prev_nxt = NULL_LNK;
      end
      ST_IN_STEP: begin
        if (cur_r != NULL_LNK) begin
          rd_en = 1'b1;
        end
      end
      ST_IN_WT: begin
        if (dq <= rem_r) begin
          rem_nxt  = rem_r - dq;
          prev_nxt = cur_r;
          cur_nxt  = nq;
        end else begin
          d_we = 1'b1;
          d_wd = dq - rem_r;
        end
      end
      ST_IN_FIN: begin
        d_we = 1'b1;
        d_wa = sid;
        d_wd = rem_r;
        n_we = 1'b1;
        n_wa = sid;
        n_wd = cur_r;
      end
      ST_IN_LINK: begin
        if (prev_r == NULL_LNK) begin
          hd_nxt = sl;
        end else begin
          n_we = 1'b1;
          n_wd = sl;
        end
        pend_nxt[sid] = 1'b1;
      end
      ST_ACK: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_ACK;
          oid_nxt   = 4'd0;
          olast_nxt = 1'b1;
        end
      end
      ST_TK_RD: begin
        rd_en   = 1'b1;
        rd_a    = hd_r[IW-1:0];
        cur_nxt = hd_r;
      end
      ST_TK_WT: begin
        nx_nxt = nq;
        if (dec != '0) begin
          d_we = 1'b1;
          d_wd = dec;
        end
      end
      ST_FR_RD: begin
        if (nx_r != NULL_LNK) begin
          rd_en = 1'b1;
          rd_a  = nx_r[IW-1:0];
        end
      end
      ST_FR_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_FIRE;
          oid_nxt   = cur_ext[3:0];
          olast_nxt = !more;
          pend_nxt[cur_r[IW-1:0]] = 1'b0;
          hd_nxt    = nx_r;
          if (more) begin
            cur_nxt = nx_r;
            nx_nxt  = nq;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      hd_r   <= NULL_LNK;
      pend_r <= '0;
      pvld_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      hd_r   <= hd_nxt;
      pend_r <= pend_nxt;
      pvld_r <= pvld_nxt;
      ov_r   <= ov_nxt;
    end
    cmd_r   <= cmd_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    nx_r    <= nx_nxt;
    dlt_r   <= dlt_nxt;
    rem_r   <= rem_nxt;
    okind_r <= okind_nxt;
    oid_r   <= oid_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.kind     = okind_r;
  assign out_ch.fired_id = oid_r;
  assign out_ch.last     = olast_r;

endmodule
